/* sv/spatiotemporal_flux_smooth_defines.svh */
// Assertion macros for the flux smoothing RTL.
// No dependencies; included by fsmooth_divide, which carries the checks.
`ifndef SPATIOTEMPORAL_FLUX_SMOOTH_DEFINES_SVH
`define SPATIOTEMPORAL_FLUX_SMOOTH_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define FS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/fsmooth_pkg.sv */
// Package for the flux smoothing block: widths, CSR codes, stage types, divide table.
// No dependencies.
package fsmooth_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int NUM_NB     = 10;              // prev, next, eight spatial
   localparam int NUM_TEMP   = 2;
   localparam int CNT_W      = 4;               // count 1..11
   localparam int SUM_W      = PIXEL_BITS + CNT_W;
   localparam int NUM_W      = SUM_W + 1;       // 2*sum + count
   localparam int DIV_W      = CNT_W + 1;       // 2*count
   localparam int RECIP_SHIFT = NUM_W + 1;
   localparam int RECIP_W    = RECIP_SHIFT;
   localparam int PROD_W     = NUM_W + RECIP_W;
   localparam int QUO_W      = PROD_W - RECIP_SHIFT;
   localparam int THR_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int DIV_MIN    = 2;
   localparam int DIV_MAX    = 2 * (NUM_NB + 1);

   localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_LIMIT     = 2'd0,
      CSR_SPACE_LIMIT    = 2'd1,
      CSR_SPATIAL_ENABLE = 2'd2
   } csr_index_type;

   // floor(2^RECIP_SHIFT / (2*count)), indexed by count
   localparam logic [RECIP_W-1:0] RECIP_TABLE [2**CNT_W] = '{
      RECIP_W'(0),
      RECIP_W'((2**RECIP_SHIFT) / 2),
      RECIP_W'((2**RECIP_SHIFT) / 4),
      RECIP_W'((2**RECIP_SHIFT) / 6),
      RECIP_W'((2**RECIP_SHIFT) / 8),
      RECIP_W'((2**RECIP_SHIFT) / 10),
      RECIP_W'((2**RECIP_SHIFT) / 12),
      RECIP_W'((2**RECIP_SHIFT) / 14),
      RECIP_W'((2**RECIP_SHIFT) / 16),
      RECIP_W'((2**RECIP_SHIFT) / 18),
      RECIP_W'((2**RECIP_SHIFT) / 20),
      RECIP_W'((2**RECIP_SHIFT) / 22),
      RECIP_W'(0),
      RECIP_W'(0),
      RECIP_W'(0),
      RECIP_W'(0)
   };

   typedef struct packed {
      logic [THR_W-1:0] temp_limit;
      logic [THR_W-1:0] space_limit;
      logic             spatial_enable;
   } cfg_type;

   typedef struct packed {
      logic                                valid;
      logic                                smooth;
      logic [PIXEL_BITS-1:0]               center;
      logic [NUM_NB-1:0]                   incl;
      logic [NUM_NB-1:0][PIXEL_BITS-1:0]   term;   // zero when not included
   } cmp_stage_type;

   typedef struct packed {
      logic                  valid;
      logic                  smooth;
      logic [PIXEL_BITS-1:0] center;
      logic [SUM_W-1:0]      sum;
      logic [CNT_W-1:0]      cnt;
   } sum_stage_type;

endpackage

/* sv/fsmooth_ifs.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on fsmooth_pkg.
interface fsmooth_req_if;
   import fsmooth_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] center_pixel;
   logic [PIXEL_BITS-1:0] prev_frame_pixel;
   logic [PIXEL_BITS-1:0] next_frame_pixel;
   logic [PIXEL_BITS-1:0] up_left_pixel;
   logic [PIXEL_BITS-1:0] up_pixel;
   logic [PIXEL_BITS-1:0] up_right_pixel;
   logic [PIXEL_BITS-1:0] left_pixel;
   logic [PIXEL_BITS-1:0] right_pixel;
   logic [PIXEL_BITS-1:0] down_left_pixel;
   logic [PIXEL_BITS-1:0] down_pixel;
   logic [PIXEL_BITS-1:0] down_right_pixel;
   logic                  edge_bypass;

   modport source (output valid, center_pixel, prev_frame_pixel, next_frame_pixel,
                   up_left_pixel, up_pixel, up_right_pixel, left_pixel, right_pixel,
                   down_left_pixel, down_pixel, down_right_pixel, edge_bypass,
                   input ready);
   modport sink   (input valid, center_pixel, prev_frame_pixel, next_frame_pixel,
                   up_left_pixel, up_pixel, up_right_pixel, left_pixel, right_pixel,
                   down_left_pixel, down_pixel, down_right_pixel, edge_bypass,
                   output ready);
endinterface

interface fsmooth_rsp_if;
   import fsmooth_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] smoothed_pixel;

   modport source (output valid, smoothed_pixel, input ready);
   modport sink   (input valid, smoothed_pixel, output ready);
endinterface

/* sv/spatiotemporal_flux_smooth.sv */
// Top level of the spatio-temporal flux smoother: CSRs, stall control, stage chain.
// Depends on fsmooth_pkg, fsmooth_ifs, fsmooth_compare, fsmooth_sum, fsmooth_divide.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+----------------------------------------
//   req_port | in  | valid/ready            | center, prev/next frame, 8 nbrs, edge
//   rsp_port | out | valid/ready            | smoothed_pixel
//   csr_*    | in  | csr_write_enable only  | csr_index, csr_write_data
//
// One word per cycle while the response is not stalled, through four register
// stages in order (compare, adder tree, reciprocal multiply, correction/output
// register); rsp_port.valid rises once the word reaches the output register.
// Synchronous active-high reset clears the stage valid bits and loads the
// thresholds to 7 and spatial enable to 1.
// A stalled response freezes all four stages together; req_port.ready is
// low only while the output word waits, so nothing is dropped or repeated.
module spatiotemporal_flux_smooth (
   input  logic                               clock,
   input  logic                               reset,
   fsmooth_req_if.sink                        req_port,
   fsmooth_rsp_if.source                      rsp_port,
   input  logic                               csr_write_enable,
   input  logic [fsmooth_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fsmooth_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import fsmooth_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          adv;
   cmp_stage_type p1;
   sum_stage_type p2;

   // pipe moves whenever the output slot is free or being drained
   assign adv            = !rsp_port.valid || rsp_port.ready;
   assign req_port.ready = adv;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_LIMIT:     cfg_in.temp_limit     = csr_write_data[THR_W-1:0];
            CSR_SPACE_LIMIT:    cfg_in.space_limit    = csr_write_data[THR_W-1:0];
            CSR_SPATIAL_ENABLE: cfg_in.spatial_enable = csr_write_data[0];
            default:            cfg_in = cfg_ff;   // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_limit     <= THR_W'(7);
         cfg_ff.space_limit    <= THR_W'(7);
         cfg_ff.spatial_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fsmooth_compare u_compare (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (cfg_ff),
      .req_port (req_port),
      .p1       (p1)
   );

   fsmooth_sum u_sum (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .p1    (p1),
      .p2    (p2)
   );

   fsmooth_divide u_divide (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .p2       (p2),
      .rsp_port (rsp_port)
   );

endmodule

/* sv/fsmooth_compare.sv */
// Stage 1: extremum test and per-neighbor threshold compare.
// Depends on fsmooth_pkg and fsmooth_ifs.
module fsmooth_compare (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  fsmooth_pkg::cfg_type cfg,
   fsmooth_req_if.sink          req_port,
   output fsmooth_pkg::cmp_stage_type p1
);
   import fsmooth_pkg::*;

   logic [NUM_NB-1:0][PIXEL_BITS-1:0] nb;
   logic [PIXEL_BITS-1:0]             ctr;
   logic [PIXEL_BITS-1:0]             diff [NUM_NB];
   logic [NUM_NB-1:0]                 incl;
   cmp_stage_type                     p1_ff, p1_in;

   always_comb begin
      ctr   = req_port.center_pixel;
      nb[0] = req_port.prev_frame_pixel;
      nb[1] = req_port.next_frame_pixel;
      nb[2] = req_port.up_left_pixel;
      nb[3] = req_port.up_pixel;
      nb[4] = req_port.up_right_pixel;
      nb[5] = req_port.left_pixel;
      nb[6] = req_port.right_pixel;
      nb[7] = req_port.down_left_pixel;
      nb[8] = req_port.down_pixel;
      nb[9] = req_port.down_right_pixel;
   end

   always_comb begin
      for (int i = 0; i < NUM_NB; i++) begin
         diff[i] = (nb[i] > ctr) ? (nb[i] - ctr) : (ctr - nb[i]);
         if (i < NUM_TEMP) begin
            incl[i] = ({{(THR_W){1'b0}}, diff[i]} <=
                       {{(PIXEL_BITS){1'b0}}, cfg.temp_limit});
         end else begin
            incl[i] = cfg.spatial_enable &&
                      ({{(THR_W){1'b0}}, diff[i]} <=
                       {{(PIXEL_BITS){1'b0}}, cfg.space_limit});
         end
      end
   end

   always_comb begin
      p1_in.valid  = req_port.valid;
      p1_in.center = ctr;
      p1_in.incl   = incl;
      p1_in.smooth = !req_port.edge_bypass &&
                     (((nb[0] < ctr) && (nb[1] < ctr)) ||
                      ((nb[0] > ctr) && (nb[1] > ctr)));
      for (int i = 0; i < NUM_NB; i++) begin
         p1_in.term[i] = incl[i] ? nb[i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid <= 1'b0;
      end else if (adv) begin
         p1_ff.valid <= p1_in.valid;
      end
      if (adv) begin
         p1_ff.smooth <= p1_in.smooth;
         p1_ff.center <= p1_in.center;
         p1_ff.incl   <= p1_in.incl;
         p1_ff.term   <= p1_in.term;
      end
   end

   assign p1 = p1_ff;

endmodule

/* sv/fsmooth_sum.sv */
// Stage 2: adder tree over the included terms plus center, and the count.
// Depends on fsmooth_pkg.
module fsmooth_sum (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  fsmooth_pkg::cmp_stage_type p1,
   output fsmooth_pkg::sum_stage_type p2
);
   import fsmooth_pkg::*;

   logic [SUM_W-1:0] t [NUM_NB];
   logic [SUM_W-1:0] pair [NUM_NB/2];
   sum_stage_type    p2_ff, p2_in;

   always_comb begin
      for (int i = 0; i < NUM_NB; i++) begin
         t[i] = {{(SUM_W-PIXEL_BITS){1'b0}}, p1.term[i]};
      end
      for (int i = 0; i < NUM_NB/2; i++) begin
         pair[i] = t[2*i] + t[2*i+1];
      end
   end

   always_comb begin
      p2_in.valid  = p1.valid;
      p2_in.smooth = p1.smooth;
      p2_in.center = p1.center;
      p2_in.sum    = ((pair[0] + pair[1]) + (pair[2] + pair[3])) +
                     (pair[4] + {{(SUM_W-PIXEL_BITS){1'b0}}, p1.center});
      p2_in.cnt    = CNT_W'($countones(p1.incl)) + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ff.valid <= 1'b0;
      end else if (adv) begin
         p2_ff.valid <= p2_in.valid;
      end
      if (adv) begin
         p2_ff.smooth <= p2_in.smooth;
         p2_ff.center <= p2_in.center;
         p2_ff.sum    <= p2_in.sum;
         p2_ff.cnt    <= p2_in.cnt;
      end
   end

   assign p2 = p2_ff;

endmodule

/* sv/fsmooth_divide.sv */
// Stages 3-4: rounded divide by reciprocal multiply, one-step correction, output register.
// Depends on fsmooth_pkg, fsmooth_ifs and the defines header.
`include "spatiotemporal_flux_smooth_defines.svh"

module fsmooth_divide (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  fsmooth_pkg::sum_stage_type p2,
   fsmooth_rsp_if.source              rsp_port
);
   import fsmooth_pkg::*;

   // stage 3
   logic                  p3_valid_ff;
   logic                  p3_smooth_ff, p3_smooth_in;
   logic [PIXEL_BITS-1:0] p3_center_ff;
   logic [NUM_W-1:0]      p3_num_ff, p3_num_in;
   logic [DIV_W-1:0]      p3_div_ff, p3_div_in;
   logic [PROD_W-1:0]     p3_prod_ff, p3_prod_in;

   // stage 4 (output)
   logic [QUO_W-1:0]      quo0;
   logic [NUM_W-1:0]      rem;
   logic [QUO_W-1:0]      quo;
   logic                  out_valid_ff;
   logic [PIXEL_BITS-1:0] out_pixel_ff, out_pixel_in;

   always_comb begin
      p3_smooth_in = p2.smooth;
      p3_num_in    = {p2.sum, 1'b0} + {{(NUM_W-CNT_W){1'b0}}, p2.cnt};
      p3_div_in    = {p2.cnt, 1'b0};
      p3_prod_in   = {{(RECIP_W){1'b0}}, p3_num_in} *
                     {{(NUM_W){1'b0}}, RECIP_TABLE[p2.cnt]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff  <= p2.valid;
         out_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_smooth_ff <= p3_smooth_in;
         p3_center_ff <= p2.center;
         p3_num_ff    <= p3_num_in;
         p3_div_ff    <= p3_div_in;
         p3_prod_ff   <= p3_prod_in;
         out_pixel_ff <= out_pixel_in;
      end
   end

   // estimate is low by at most one
   always_comb begin
      quo0 = p3_prod_ff[PROD_W-1:RECIP_SHIFT];
      rem  = p3_num_ff - NUM_W'(quo0 * {{(QUO_W-DIV_W){1'b0}}, p3_div_ff});
      quo  = (rem >= {{(NUM_W-DIV_W){1'b0}}, p3_div_ff}) ? quo0 + QUO_W'(1) : quo0;
      if (!p3_smooth_ff) begin
         out_pixel_in = p3_center_ff;
      end else if (quo > {{(QUO_W-PIXEL_BITS){1'b0}}, PIX_MAX}) begin
         out_pixel_in = PIX_MAX;
      end else begin
         out_pixel_in = quo[PIXEL_BITS-1:0];
      end
   end

   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.smoothed_pixel = out_pixel_ff;

   `FS_ASSERT_IMP(a_div_range, clock, reset, p3_valid_ff && p3_smooth_ff, (p3_div_ff >= DIV_W'(DIV_MIN)) && (p3_div_ff <= DIV_W'(DIV_MAX)), "divisor out of range")
   `FS_ASSERT_IMP(a_rem_bound, clock, reset, p3_valid_ff && p3_smooth_ff, ({1'b0, rem} < ({1'b0, {{(NUM_W-DIV_W){1'b0}}, p3_div_ff}} << 1)), "reciprocal estimate off by more than one")
   `FS_ASSERT_NXT(a_passthru, clock, reset, adv && p3_valid_ff && !p3_smooth_ff, out_pixel_ff == $past(p3_center_ff), "bypass word lost its center")

endmodule

/* tb/sv/flux_smooth_checker.sv */
// Checker for the flux smoothing block: watches request, response and CSR traffic,
// predicts every smoothed pixel and compares the results in order.
// Depends on fsmooth_pkg and fsmooth_ifs.
module flux_smooth_checker (
   input  logic                               clock,
   input  logic                               reset,
   fsmooth_req_if                             req_mon,
   fsmooth_rsp_if                             rsp_mon,
   input  logic                               csr_write_enable,
   input  logic [fsmooth_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fsmooth_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                                 fail_count,
   output int                                 checked_count,
   output int                                 pending_words
);
   import fsmooth_pkg::*;

   localparam int               NUM_SPATIAL  = NUM_NB - NUM_TEMP;
   localparam logic [THR_W-1:0] THR_AT_RESET = 8'd7;

   cfg_type               live_cfg;
   logic [PIXEL_BITS-1:0] smoothed_due [$];
   logic [PIXEL_BITS-1:0] want;
   int                    mismatches;
   int                    compared;

   function automatic bit within_reach(input logic [PIXEL_BITS-1:0] a, b,
                                       input logic [THR_W-1:0] thr);
      int gap;
      gap = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
      return gap <= int'(thr);
   endfunction

   // Averages the center with every neighbor close enough to it, rounded half up.
   function automatic logic [PIXEL_BITS-1:0] flux_average(
      input cfg_type                                cfg,
      input logic [PIXEL_BITS-1:0]                  ctr, prv, nxt,
      input logic [NUM_SPATIAL-1:0][PIXEL_BITS-1:0] nbr,
      input logic                                   at_border);
      int sum;
      int cnt;
      int q;
      if (at_border || !((prv < ctr && nxt < ctr) || (prv > ctr && nxt > ctr)))
         return ctr;
      sum = ctr;
      cnt = 1;
      if (within_reach(prv, ctr, cfg.temp_limit)) begin
         sum += prv;
         cnt++;
      end
      if (within_reach(nxt, ctr, cfg.temp_limit)) begin
         sum += nxt;
         cnt++;
      end
      if (cfg.spatial_enable) begin
         for (int k = 0; k < NUM_SPATIAL; k++) begin
            if (within_reach(nbr[k], ctr, cfg.space_limit)) begin
               sum += nbr[k];
               cnt++;
            end
         end
      end
      q = (2 * sum + cnt) / (2 * cnt);
      if (q > int'(PIX_MAX))
         q = int'(PIX_MAX);
      return PIXEL_BITS'(q);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         live_cfg.temp_limit     = THR_AT_RESET;
         live_cfg.space_limit    = THR_AT_RESET;
         live_cfg.spatial_enable = 1'b1;
         smoothed_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (smoothed_due.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got %0d",
                        $time, rsp_mon.smoothed_pixel);
               mismatches++;
            end else begin
               want = smoothed_due.pop_front();
               compared++;
               if (rsp_mon.smoothed_pixel !== want) begin
                  $display("%0t: smoothed_pixel mismatch, expected %0d, got %0d",
                           $time, want, rsp_mon.smoothed_pixel);
                  mismatches++;
               end
            end
         end
         // prediction uses the settings in force before any write at this edge
         if (req_mon.valid && req_mon.ready)
            smoothed_due.push_back(flux_average(live_cfg,
               req_mon.center_pixel, req_mon.prev_frame_pixel, req_mon.next_frame_pixel,
               {req_mon.down_right_pixel, req_mon.down_pixel, req_mon.down_left_pixel,
                req_mon.right_pixel, req_mon.left_pixel, req_mon.up_right_pixel,
                req_mon.up_pixel, req_mon.up_left_pixel},
               req_mon.edge_bypass));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TEMP_LIMIT:     live_cfg.temp_limit     = csr_write_data;
               CSR_SPACE_LIMIT:    live_cfg.space_limit    = csr_write_data;
               CSR_SPATIAL_ENABLE: live_cfg.spatial_enable = csr_write_data[0];
               default: ;
            endcase
         end
      end
      pending_words <= smoothed_due.size();
      fail_count    <= mismatches;
      checked_count <= compared;
   end

endmodule

/* tb/sv/spatiotemporal_flux_smooth_tb.sv */
// Top of the flux smoothing testbench: clock, reset, pixel word stimulus, CSR phases
// and the verdict; prediction and comparison live in flux_smooth_checker.
// Depends on fsmooth_pkg, fsmooth_ifs, flux_smooth_checker and the block itself.
module spatiotemporal_flux_smooth_tb;
   import fsmooth_pkg::*;

   localparam int NUM_SPATIAL     = NUM_NB - NUM_TEMP;
   localparam int PIPE_LATENCY    = 4;       // register stages from req to rsp
   localparam int RESET_CYCLES    = 11;
   localparam int NUM_PHASES      = 8;       // register settings, phase 0 = reset values
   localparam int WORDS_PER_PHASE = 168;
   localparam int CYCLE_LIMIT     = 400000;  // far above the slowest legal run
   localparam int DIR_BELOW       = -1;
   localparam int DIR_ANY         = 0;
   localparam int DIR_ABOVE       = 1;

   // index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REGISTER = 2'd3;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]                  center;
      logic [PIXEL_BITS-1:0]                  prev_frame;
      logic [PIXEL_BITS-1:0]                  next_frame;
      logic [NUM_SPATIAL-1:0][PIXEL_BITS-1:0] nbr;     // [0] = up-left ... [7] = down-right
      logic                                   at_border;
   } pixel_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int fail_count;
   int checked_count;
   int pending_words;
   int words_sent;
   int cycle_count;
   int send_idle_pct;   // chance per cycle that the sender holds off
   int rsp_stall_pct;   // chance per cycle that the receiver stalls

   fsmooth_req_if req_ch ();
   fsmooth_rsp_if rsp_ch ();

   spatiotemporal_flux_smooth i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_ch),
      .rsp_port         (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   flux_smooth_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .checked_count    (checked_count),
      .pending_words    (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver side: random stalls at the rate of the current phase.
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Watchdog: a hung pipe or a lost word ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stopped at the cycle limit, %0d words still due",
                  $time, pending_words);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic pixel_word_type make_word(
      input logic [PIXEL_BITS-1:0]                  ctr, prv, nxt,
      input logic [NUM_SPATIAL-1:0][PIXEL_BITS-1:0] nbr,
      input logic                                   at_border);
      pixel_word_type w;
      w.center     = ctr;
      w.prev_frame = prv;
      w.next_frame = nxt;
      w.nbr        = nbr;
      w.at_border  = at_border;
      return w;
   endfunction

   // Spread of a neighbor around the center: mostly near the thresholds in use,
   // sometimes the whole pixel range.
   function automatic int random_span();
      case ($urandom_range(4))
         0:       return 3;
         1:       return 8;
         2:       return 16;
         3:       return 64;
         default: return 255;
      endcase
   endfunction

   // A pixel strictly below, strictly above or anywhere within span of ctr,
   // clamped to the pixel range.
   function automatic logic [PIXEL_BITS-1:0] pixel_near(input int ctr, span, dir);
      int v;
      if (dir == DIR_BELOW)
         v = ctr - int'($urandom_range(span, 1));
      else if (dir == DIR_ABOVE)
         v = ctr + int'($urandom_range(span, 1));
      else
         v = ctr + int'($urandom_range(2 * span)) - span;
      if (v < 0)
         v = 0;
      if (v > int'(PIX_MAX))
         v = int'(PIX_MAX);
      return PIXEL_BITS'(v);
   endfunction

   // Mostly strict temporal extrema (the smoothing path) with neighbors close to
   // the center; most of the rest pass the center through for one reason or another.
   function automatic pixel_word_type random_word();
      pixel_word_type w;
      int             c;
      int             t_span;
      int             s_span;
      int             shape;
      int             dir;
      if ($urandom_range(9) == 0)
         c = $urandom_range(1) ? int'(PIX_MAX) : 0;
      else
         c = $urandom_range(int'(PIX_MAX));
      t_span   = random_span();
      s_span   = random_span();
      shape    = $urandom_range(99);
      w.center = PIXEL_BITS'(c);
      if (shape < 65) begin
         dir = (c == int'(PIX_MAX) || (c != 0 && $urandom_range(1) == 1)) ?
               DIR_BELOW : DIR_ABOVE;
         w.prev_frame = pixel_near(c, t_span, dir);
         w.next_frame = pixel_near(c, t_span, dir);
      end else if (shape < 75) begin
         w.prev_frame = w.center;
         w.next_frame = pixel_near(c, t_span, DIR_ANY);
      end else if (shape < 85) begin
         w.prev_frame = pixel_near(c, t_span, DIR_ANY);
         w.next_frame = w.center;
      end else if (shape < 93) begin
         // one above, one below: no extremum
         dir          = $urandom_range(1) ? DIR_BELOW : DIR_ABOVE;
         w.prev_frame = pixel_near(c, t_span, dir);
         w.next_frame = pixel_near(c, t_span, -dir);
      end else begin
         w.prev_frame = PIXEL_BITS'($urandom_range(int'(PIX_MAX)));
         w.next_frame = PIXEL_BITS'($urandom_range(int'(PIX_MAX)));
      end
      for (int k = 0; k < NUM_SPATIAL; k++)
         w.nbr[k] = pixel_near(c, s_span, DIR_ANY);
      w.at_border = ($urandom_range(99) < 12);
      return w;
   endfunction

   // Offers one word, with random hold-off first, and returns at the edge
   // that accepts it. valid stays high; the caller's next drive decides.
   task automatic push_word(input pixel_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.center_pixel     <= w.center;
      req_ch.prev_frame_pixel <= w.prev_frame;
      req_ch.next_frame_pixel <= w.next_frame;
      req_ch.up_left_pixel    <= w.nbr[0];
      req_ch.up_pixel         <= w.nbr[1];
      req_ch.up_right_pixel   <= w.nbr[2];
      req_ch.left_pixel       <= w.nbr[3];
      req_ch.right_pixel      <= w.nbr[4];
      req_ch.down_left_pixel  <= w.nbr[5];
      req_ch.down_pixel       <= w.nbr[6];
      req_ch.down_right_pixel <= w.nbr[7];
      req_ch.edge_bypass      <= w.at_border;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      words_sent++;
   endtask

   // Stop sending and wait until every predicted word has come back.
   // It waits before polling so the checker's count includes the last accept.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending_words != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_flow(input int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
         default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
      endcase
   endtask

   // Register settings per phase; values stick until written again.
   task automatic apply_setting(input int phase);
      case (phase)
         1: begin
            write_reg(CSR_TEMP_LIMIT, 8'd0);
            write_reg(CSR_SPACE_LIMIT, 8'd0);
         end
         2: begin
            write_reg(CSR_TEMP_LIMIT, 8'd255);
            write_reg(CSR_SPACE_LIMIT, 8'd255);
         end
         3: begin
            // only bit 0 of the enable counts: this turns spatial mode off
            write_reg(CSR_SPATIAL_ENABLE, 8'hFE);
            write_reg(CSR_NO_REGISTER, 8'h00);
         end
         4: begin
            write_reg(CSR_TEMP_LIMIT, CSR_DATA_W'($urandom_range(31)));
            write_reg(CSR_SPACE_LIMIT, CSR_DATA_W'($urandom_range(31)));
            write_reg(CSR_SPATIAL_ENABLE, 8'hFF);
         end
         5: begin
            write_reg(CSR_TEMP_LIMIT, 8'd0);
            write_reg(CSR_SPACE_LIMIT, 8'd255);
         end
         6: begin
            write_reg(CSR_TEMP_LIMIT, 8'd255);
            write_reg(CSR_SPACE_LIMIT, 8'd0);
            write_reg(CSR_SPATIAL_ENABLE, 8'h00);
         end
         default: begin
            write_reg(CSR_TEMP_LIMIT, CSR_DATA_W'($urandom_range(255)));
            write_reg(CSR_SPACE_LIMIT, CSR_DATA_W'($urandom_range(255)));
            write_reg(CSR_SPATIAL_ENABLE, CSR_DATA_W'($urandom_range(255)));
         end
      endcase
   endtask

   initial begin
      cycle_count             = 0;
      words_sent              = 0;
      send_idle_pct           = 0;
      rsp_stall_pct           = 0;
      reset                   = 1'b1;
      csr_write_enable        = 1'b0;
      csr_index               = '0;
      csr_write_data          = '0;
      req_ch.valid            = 1'b0;
      req_ch.center_pixel     = '0;
      req_ch.prev_frame_pixel = '0;
      req_ch.next_frame_pixel = '0;
      req_ch.up_left_pixel    = '0;
      req_ch.up_pixel         = '0;
      req_ch.up_right_pixel   = '0;
      req_ch.left_pixel       = '0;
      req_ch.right_pixel      = '0;
      req_ch.down_left_pixel  = '0;
      req_ch.down_pixel       = '0;
      req_ch.down_right_pixel = '0;
      req_ch.edge_bypass      = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings (thresholds 7, spatial on).
      set_flow(0);
      push_word(make_word(8'd0, 8'd0, 8'd0, {8{8'd0}}, 1'b0));
      push_word(make_word(8'd255, 8'd255, 8'd255, {8{8'd255}}, 1'b0));
      // top of range, everything averaged in
      push_word(make_word(8'd255, 8'd254, 8'd250, {8{8'd255}}, 1'b0));
      // bottom of range; the neighbor at distance 8 is left out
      push_word(make_word(8'd0, 8'd1, 8'd7,
                          {8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1}, 1'b0));
      // extremum but nothing close: center alone
      push_word(make_word(8'd0, 8'd8, 8'd255, {8{8'd255}}, 1'b0));
      // edge pixels pass the center even on an extremum
      push_word(make_word(8'd100, 8'd99, 8'd98, {8{8'd100}}, 1'b1));
      push_word(make_word(8'd255, 8'd0, 8'd0, {8{8'd0}}, 1'b1));
      // no strict extremum: equal prev, equal next, straddling
      push_word(make_word(8'd50, 8'd50, 8'd40, {8{8'd45}}, 1'b0));
      push_word(make_word(8'd50, 8'd45, 8'd50, {8{8'd45}}, 1'b0));
      push_word(make_word(8'd50, 8'd60, 8'd40, {8{8'd50}}, 1'b0));
      // threshold boundary both sides, temporal and spatial
      push_word(make_word(8'd100, 8'd93, 8'd92,
                          {8'd107, 8'd108, 8'd93, 8'd92, 8'd100, 8'd101, 8'd99, 8'd0},
                          1'b0));
      // exact half rounds up: (10 + 9) / 2
      push_word(make_word(8'd10, 8'd9, 8'd0, {8{8'd255}}, 1'b0));
      push_word(make_word(8'd200, 8'd201, 8'd207,
                          {8'd193, 8'd194, 8'd199, 8'd200, 8'd206, 8'd207, 8'd208, 8'd192},
                          1'b0));
      push_word(make_word(8'd128, 8'd127, 8'd121,
                          {8'd0, 8'd255, 8'd121, 8'd135, 8'd136, 8'd120, 8'd128, 8'd255},
                          1'b0));
      // small average rounds down to zero
      push_word(make_word(8'd1, 8'd0, 8'd0, {8{8'd0}}, 1'b0));
      // largest sum: rounds to full scale
      push_word(make_word(8'd254, 8'd255, 8'd255, {8{8'd255}}, 1'b0));
      push_word(make_word(8'd255, 8'd0, 8'd0, {8{8'd248}}, 1'b0));
      // alternating bit patterns
      push_word(make_word(8'hAA, 8'h55, 8'h55,
                          {8'hAA, 8'h55, 8'hAB, 8'hA9, 8'hFF, 8'h00, 8'hA5, 8'hAF}, 1'b0));
      drain_results();

      // Random phases: one register setting and one flow mix each, with a full
      // drain halfway through so the pipe also restarts from empty.
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_flow(p);
         if (p > 0)
            apply_setting(p);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (i == WORDS_PER_PHASE / 2)
               drain_results();
            push_word(random_word());
         end
         drain_results();
      end

      $display("Summary: %0d pixel words sent over %0d register settings and four flow mixes",
               words_sent, NUM_PHASES);
      $display("Summary: %0d smoothed words compared, %0d mismatches",
               checked_count, fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
